// ----- src/dfb_pkg.sv -----
// ----------------------------------------------------------------------------
// dfb_pkg: shared types and constants for the decimal to binary32 converter
// Request and result layouts, field widths and the power of ten table.
// ----------------------------------------------------------------------------
package dfb_pkg;

    localparam int INT_W       = 31;
    localparam int FRAC_W      = 30;
    localparam int DIG_W       = 4;
    localparam int EXP_W       = 8;
    localparam int MANT_W      = 23;
    localparam int MAX_DIGITS  = 9;
    localparam int EXP_BIAS    = 127;
    localparam int EXP_TOP     = EXP_BIAS + INT_W - 1;
    localparam int MAX_SHIFT   = 2 * INT_W - 2;
    localparam int SHIFT_W     = $clog2(MAX_SHIFT + 1);

    typedef struct packed {
        logic              negative;
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_numer;
        logic [DIG_W-1:0]  frac_digits;
    } t_req;

    typedef struct packed {
        logic              sign_bit;
        logic [EXP_W-1:0]  exponent_field;
        logic [MANT_W-1:0] mantissa_field;
    } t_result;

    typedef struct packed {
        logic              frac_bit;
        logic [FRAC_W-1:0] rem;
    } t_frac_step;

    function automatic logic [FRAC_W-1:0] pow_ten(input logic [DIG_W-1:0] digits);
        logic [FRAC_W-1:0] p;
        begin
            case (digits)
                4'd0:    p = FRAC_W'(1);
                4'd1:    p = FRAC_W'(10);
                4'd2:    p = FRAC_W'(100);
                4'd3:    p = FRAC_W'(1000);
                4'd4:    p = FRAC_W'(10000);
                4'd5:    p = FRAC_W'(100000);
                4'd6:    p = FRAC_W'(1000000);
                4'd7:    p = FRAC_W'(10000000);
                4'd8:    p = FRAC_W'(100000000);
                default: p = FRAC_W'(1000000000);
            endcase
            return p;
        end
    endfunction

endpackage

// ----- src/dfb_frac_unit.sv -----
// ----------------------------------------------------------------------------
// dfb_frac_unit: fraction bit generator
// Doubles the decimal remainder and subtracts the power of ten when it fits,
// giving one binary fraction bit per use.
// ----------------------------------------------------------------------------
module dfb_frac_unit (
    input  logic [dfb_pkg::FRAC_W-1:0] i_rem,
    input  logic [dfb_pkg::FRAC_W-1:0] i_pow,
    output dfb_pkg::t_frac_step        o_step
);
    import dfb_pkg::*;

    logic [FRAC_W:0] doubled;
    logic [FRAC_W:0] diff;
    logic            fits;

    assign doubled = {i_rem, 1'b0};
    assign diff    = doubled - {1'b0, i_pow};
    assign fits    = doubled >= {1'b0, i_pow};

    assign o_step.frac_bit = fits;
    assign o_step.rem      = fits ? diff[FRAC_W-1:0] : doubled[FRAC_W-1:0];

endmodule

// ----- src/decimal_fixed_to_binary32.sv -----
// ----------------------------------------------------------------------------
// decimal_fixed_to_binary32: decimal fixed-point to IEEE single converter
// A request passes through s normalizing shifts before o_done, where s
// is 0 to 60, with one fraction step per shift.
// busy is high while normalizing; a new request is taken only when idle.
// An exact zero skips the shift loop and is finished straight from idle.
// Synchronous active-low reset returns the block to idle with no result.
// ----------------------------------------------------------------------------
module decimal_fixed_to_binary32 (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dfb_pkg::t_req    i_req,
    output logic             o_done,
    output dfb_pkg::t_result o_result
);
    import dfb_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_NORM = 1'b1;

    logic               r_state, n_state;
    logic               r_done, n_done;
    t_result            r_result, n_result;
    logic               r_neg, n_neg;
    logic [INT_W-1:0]   r_x, n_x;
    logic [FRAC_W-1:0]  r_rem, n_rem;
    logic [FRAC_W-1:0]  r_pow, n_pow;
    logic [SHIFT_W-1:0] r_shift, n_shift;

    logic [DIG_W-1:0]   digits_eff;
    logic [FRAC_W-1:0]  pow_in;
    logic [FRAC_W-1:0]  rem_in;
    logic               accept;
    t_frac_step         step;

    dfb_frac_unit u_frac (
        .i_rem  (r_rem),
        .i_pow  (r_pow),
        .o_step (step)
    );

    assign accept     = start && !busy;
    assign digits_eff = (i_req.frac_digits > DIG_W'(MAX_DIGITS)) ?
                        DIG_W'(MAX_DIGITS) : i_req.frac_digits;
    assign pow_in     = pow_ten(digits_eff);
    assign rem_in     = (i_req.frac_numer >= pow_in) ? pow_in - FRAC_W'(1)
                                                     : i_req.frac_numer;

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_result = r_result;
        n_neg    = r_neg;
        n_x      = r_x;
        n_rem    = r_rem;
        n_pow    = r_pow;
        n_shift  = r_shift;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_neg   = i_req.negative;
                    n_x     = i_req.int_part;
                    n_rem   = rem_in;
                    n_pow   = pow_in;
                    n_shift = '0;
                    if ((i_req.int_part == '0) && (rem_in == '0)) begin
                        n_done                  = 1'b1;
                        n_result.sign_bit       = i_req.negative;
                        n_result.exponent_field = '0;
                        n_result.mantissa_field = '0;
                    end else begin
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (r_x[INT_W-1]) begin
                    n_state                 = S_IDLE;
                    n_done                  = 1'b1;
                    n_result.sign_bit       = r_neg;
                    n_result.exponent_field = EXP_W'(EXP_TOP - int'(r_shift));
                    n_result.mantissa_field = r_x[INT_W-2 -: MANT_W];
                end else begin
                    n_x     = {r_x[INT_W-2:0], step.frac_bit};
                    n_rem   = step.rem;
                    n_shift = r_shift + SHIFT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_result <= n_result;
        r_neg    <= n_neg;
        r_x      <= n_x;
        r_rem    <= n_rem;
        r_pow    <= n_pow;
        r_shift  <= n_shift;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_shift_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) && !r_x[INT_W-1] |=> r_shift == $past(r_shift) + SHIFT_W'(1))
        else $error("Shift count did not advance during normalization.");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> r_shift <= SHIFT_W'(MAX_SHIFT))
        else $error("Normalization ran past the longest possible search.");

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.exponent_field == '0) |-> o_result.mantissa_field == '0)
        else $error("Zero exponent issued with a nonzero mantissa.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("Result issued while a request is still in progress.");

endmodule
